### src/tmes_pkg.sv
// ----------------------------------------------------------------------------
// Tiled matrix element store: shared definitions
// Field widths, register indexes, reset values and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmes_pkg;

   localparam int MAX_DIM_DEFAULT     = 64;
   localparam int STORE_DEPTH_DEFAULT = 4096;

   localparam int CFG_W     = 7;   // width of each configuration register
   localparam int CSR_IDX_W = 2;   // configuration register index
   localparam int IDX_W     = 6;   // row and column index width
   localparam int WORD_W    = 64;  // element word
   localparam int FLAT_W    = 12;  // reported flat position
   localparam int PROD_W    = 2 * CFG_W;
   // The position never reaches 2**15 for 6-bit indexes and 7-bit sizes.
   localparam int POS_W     = 15;

   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_ROWS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_COLS   = 2'd3;

   localparam logic [CFG_W-1:0] MATRIX_ROWS_RESET = 7'd64;
   localparam logic [CFG_W-1:0] MATRIX_COLS_RESET = 7'd64;
   localparam logic [CFG_W-1:0] TILE_ROWS_RESET   = 7'd8;
   localparam logic [CFG_W-1:0] TILE_COLS_RESET   = 7'd8;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef struct packed {
      logic load;      // capture the request and start both dividers
      logic div_step;  // one quotient bit per divider
      logic mul_a;     // tile sizes and partial products
      logic mul_b;     // flat position
      logic access;    // memory read or write
      logic respond;   // result beat on the output ports
   } tmes_cmd_type;

   typedef struct packed {
      logic out_of_range;
   } tmes_status_type;

   // A size of zero acts as one, and a size above the cap acts as the cap.
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] cap);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > cap) begin
         r = cap;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### src/tiled_matrix_element_store.sv
// ----------------------------------------------------------------------------
// Tiled matrix element store
// Holds a matrix of 64-bit words in tiled column-major layout and reads or
// writes one element per access, reporting its flat position.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  request   req_kind, req_row_index, req_col_index,  start high, busy low
//            req_write_value
//  result    rsp_read_value, rsp_flat_position,       rsp_valid, one cycle
//            rsp_out_of_range
//  config    csr_index, csr_write_data                csr_write_enable
//
// An access runs six steps of the tile dividers, the product steps and the
// memory access, then gives the result beat.
// An access outside the matrix skips the arithmetic and goes to the result.
// Reset (synchronous) restores the register defaults; the memory is not
// cleared. The receiver cannot stall the result beat.
// ----------------------------------------------------------------------------
module tiled_matrix_element_store import tmes_pkg::*; #(
   parameter int MAX_DIM     = MAX_DIM_DEFAULT,
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   input  logic [WORD_W-1:0]    req_write_value,
   output logic                 rsp_valid,
   output logic [WORD_W-1:0]    rsp_read_value,
   output logic [FLAT_W-1:0]    rsp_flat_position,
   output logic                 rsp_out_of_range,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   tmes_cmd_type    cmd;
   tmes_status_type status;

   tmes_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   tmes_datapath #(
      .MAX_DIM     (MAX_DIM),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_kind          (req_kind),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_write_value   (req_write_value),
      .rsp_read_value    (rsp_read_value),
      .rsp_flat_position (rsp_flat_position),
      .rsp_out_of_range  (rsp_out_of_range)
   );

   assign rsp_valid = cmd.respond;

`ifndef NO_ASSERTIONS
   // The result beat lasts a single cycle.
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // A result only appears while an access is in progress.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe without an access in progress");

   // An accepted beat makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start an access");

   // An access outside the matrix reports neither a word nor a position.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_read_value == '0 && rsp_flat_position == '0))
      else $error("out-of-range result carries data");
`endif

endmodule

### src/tmes_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a row or column index by a tile size, one quotient
// bit per step; IDX_W steps give the tile number and the offset in the tile.
// ----------------------------------------------------------------------------
module tmes_div import tmes_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [IDX_W-1:0] dividend,
   input  logic [CFG_W-1:0] divisor,
   output logic [IDX_W-1:0] quotient,
   output logic [CFG_W-1:0] remainder
);

   logic [CFG_W:0]   acc_ff;
   logic [IDX_W-1:0] quo_ff;
   logic [CFG_W-1:0] div_ff;
   logic [CFG_W:0]   trial;
   logic             fits;

   assign trial = {acc_ff[CFG_W-1:0], quo_ff[IDX_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (step) begin
         acc_ff <= fits ? (trial - {1'b0, div_ff}) : trial;
         quo_ff <= {quo_ff[IDX_W-2:0], fits};
      end
   end

   assign quotient  = quo_ff;
   assign remainder = acc_ff[CFG_W-1:0];

endmodule

### src/tmes_datapath.sv
// ----------------------------------------------------------------------------
// Tiled matrix element store: datapath
// Configuration registers, request capture, tile dividers, position
// arithmetic and the element memory.
// ----------------------------------------------------------------------------
module tmes_datapath import tmes_pkg::*; #(
   parameter int MAX_DIM     = MAX_DIM_DEFAULT,
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tmes_cmd_type         cmd,
   output tmes_status_type      status,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_kind,
   input  logic [IDX_W-1:0]     req_row_index,
   input  logic [IDX_W-1:0]     req_col_index,
   input  logic [WORD_W-1:0]    req_write_value,
   output logic [WORD_W-1:0]    rsp_read_value,
   output logic [FLAT_W-1:0]    rsp_flat_position,
   output logic                 rsp_out_of_range
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int EXT_W  = POS_W + ADDR_W;
   localparam logic [CFG_W-1:0] DIM_CAP =
      (MAX_DIM >= (1 << CFG_W)) ? {CFG_W{1'b1}} : CFG_W'(MAX_DIM);

   logic [CFG_W-1:0]  matrix_rows_ff, matrix_cols_ff, tile_rows_ff, tile_cols_ff;
   logic [CFG_W-1:0]  m_eff, n_eff, tr_eff, tc_eff;

   logic              kind_ff, oor_ff, oor_in;
   logic [IDX_W-1:0]  row_ff, col_ff;
   logic [WORD_W-1:0] wdata_ff, rdata_ff;

   logic [IDX_W-1:0]  ti, tj;
   logic [CFG_W-1:0]  rmod, cmod;
   logic [CFG_W-1:0]  span_r, span_c, h, w;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_c_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic [EXT_W-1:0]  pos_ext;
   logic [ADDR_W-1:0] addr;
   logic              in_store, mem_write;

   logic [WORD_W-1:0] store_mem [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_rows_ff <= MATRIX_ROWS_RESET;
         matrix_cols_ff <= MATRIX_COLS_RESET;
         tile_rows_ff   <= TILE_ROWS_RESET;
         tile_cols_ff   <= TILE_COLS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_MATRIX_ROWS: matrix_rows_ff <= csr_write_data;
            REG_MATRIX_COLS: matrix_cols_ff <= csr_write_data;
            REG_TILE_ROWS:   tile_rows_ff   <= csr_write_data;
            REG_TILE_COLS:   tile_cols_ff   <= csr_write_data;
            default:         ;
         endcase
      end
   end

   assign m_eff  = clamp_size(matrix_rows_ff, DIM_CAP);
   assign n_eff  = clamp_size(matrix_cols_ff, DIM_CAP);
   assign tr_eff = clamp_size(tile_rows_ff, m_eff);
   assign tc_eff = clamp_size(tile_cols_ff, n_eff);

   assign oor_in = ({1'b0, req_row_index} >= m_eff) || ({1'b0, req_col_index} >= n_eff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         row_ff   <= req_row_index;
         col_ff   <= req_col_index;
         wdata_ff <= req_write_value;
         oor_ff   <= oor_in;
      end
   end

   assign status.out_of_range = oor_ff;

   tmes_div u_div_row (
      .clock     (clock),
      .load      (cmd.load),
      .step      (cmd.div_step),
      .dividend  (req_row_index),
      .divisor   (tr_eff),
      .quotient  (ti),
      .remainder (rmod)
   );

   tmes_div u_div_col (
      .clock     (clock),
      .load      (cmd.load),
      .step      (cmd.div_step),
      .dividend  (req_col_index),
      .divisor   (tc_eff),
      .quotient  (tj),
      .remainder (cmod)
   );

   // The tile start is the index less its offset; an edge tile is cut short
   // where the matrix ends before a full tile does.
   assign span_r = m_eff - ({1'b0, row_ff} - rmod);
   assign span_c = n_eff - ({1'b0, col_ff} - cmod);
   assign h      = (span_r < tr_eff) ? span_r : tr_eff;
   assign w      = (span_c < tc_eff) ? span_c : tc_eff;

   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         prod_a_ff <= PROD_W'(tr_eff) * PROD_W'(w);
         prod_b_ff <= PROD_W'(tc_eff) * PROD_W'(m_eff);
         prod_c_ff <= PROD_W'(cmod) * PROD_W'(h);
      end
   end

   assign pos_in = (POS_W'(prod_a_ff) * POS_W'(ti)) + (POS_W'(prod_b_ff) * POS_W'(tj))
                 + POS_W'(prod_c_ff) + POS_W'(rmod);

   always_ff @(posedge clock) begin
      if (cmd.mul_b) begin
         pos_ff <= pos_in;
      end
   end

   assign pos_ext   = {{ADDR_W{1'b0}}, pos_ff};
   assign addr      = pos_ext[ADDR_W-1:0];
   assign in_store  = (pos_ext < EXT_W'(STORE_DEPTH));
   assign mem_write = cmd.access && (kind_ff == KIND_WRITE) && !oor_ff && in_store;

   always_ff @(posedge clock) begin
      if (mem_write) begin
         store_mem[addr] <= wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rsp_read_value    = ((kind_ff == KIND_READ) && !oor_ff && in_store) ? rdata_ff : '0;
   assign rsp_flat_position = oor_ff ? '0 : pos_ff[FLAT_W-1:0];
   assign rsp_out_of_range  = oor_ff;

endmodule

### src/tmes_ctrl.sv
// ----------------------------------------------------------------------------
// Tiled matrix element store: controller
// Sequences one access: division, two product steps, the memory access and
// the result beat. An access outside the matrix goes straight to the result.
// ----------------------------------------------------------------------------
module tmes_ctrl import tmes_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  tmes_status_type status,
   output tmes_cmd_type    cmd,
   output logic            busy
);

   localparam int CNT_W = $clog2(IDX_W);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_DIVIDE  = 6'b000010,
      ST_MUL_A   = 6'b000100,
      ST_MUL_B   = 6'b001000,
      ST_ACCESS  = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (status.out_of_range) begin
               state_in = ST_RESPOND;
            end else if (cnt_ff == CNT_W'(IDX_W - 1)) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A:   state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_ACCESS;
         ST_ACCESS:  state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign cmd.load     = (state_ff == ST_IDLE) && start;
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.mul_a    = (state_ff == ST_MUL_A);
   assign cmd.mul_b    = (state_ff == ST_MUL_B);
   assign cmd.access   = (state_ff == ST_ACCESS);
   assign cmd.respond  = (state_ff == ST_RESPOND);

endmodule
